// ===== hw/rtl/circle_polyline_hit_test_defines.svh =====
// Assertion macros for the circle versus polyline hit test.
`ifndef CIRCLE_POLYLINE_HIT_TEST_DEFINES_SVH
`define CIRCLE_POLYLINE_HIT_TEST_DEFINES_SVH

// Check cons in the same cycle as ante.
`define CPH_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cph assertion failed: same-cycle implication");

// Check cons in the cycle after ante.
`define CPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cph assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/cph_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, command types and the multiply step table of the circle hit test.
package cph_pkg;

  localparam int COORD_W   = 24;
  localparam int RAD_W     = 23;
  localparam int HW_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int EXT_W     = COORD_W + 4;
  localparam int RW_W      = RAD_W + 1;
  localparam int RW2_W     = 2 * RW_W;
  localparam int MAG_W     = 26;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int LEN2_W    = 50;
  localparam int DOT_W     = 52;
  localparam int CMAG_W    = PROD_W;
  localparam int ACC_W     = 105;
  localparam int STEP_W    = 5;

  localparam logic [STEP_W-1:0] LAST_STEP  = 5'd17;
  localparam logic [STEP_W-1:0] POINT_STEP = 5'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OPND_ZERO = 4'd0,
    OPND_DDX  = 4'd1,
    OPND_DDY  = 4'd2,
    OPND_R    = 4'd3,
    OPND_DX   = 4'd4,
    OPND_DY   = 4'd5,
    OPND_EX   = 4'd6,
    OPND_EY   = 4'd7,
    OPND_RW   = 4'd8,
    OPND_A0   = 4'd9,
    OPND_A1   = 4'd10,
    OPND_B0   = 4'd11,
    OPND_B1   = 4'd12,
    OPND_C0   = 4'd13,
    OPND_C1   = 4'd14
  } opnd_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_SET  = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_t;

  typedef enum logic [1:0] {
    SH_0   = 2'd0,
    SH_LO  = 2'd1,
    SH_LO1 = 2'd2,
    SH_HI  = 2'd3
  } shift_t;

  typedef enum logic [2:0] {
    CAP_NONE = 3'd0,
    CAP_LEN2 = 3'd1,
    CAP_DOT  = 3'd2,
    CAP_CR   = 3'd3,
    CAP_DIST = 3'd4
  } cap_t;

  typedef struct packed {
    opnd_t   a_sel;
    opnd_t   b_sel;
    acc_op_t acc_op;
    shift_t  shift;
    cap_t    cap;
  } mul_cmd_t;

  typedef struct packed {
    logic     load;
    logic     finish;
    mul_cmd_t mul;
  } dp_cmd_t;

  localparam mul_cmd_t MUL_NOP = '{OPND_ZERO, OPND_ZERO, ACC_HOLD, SH_0, CAP_NONE};

  // Segment test first (projection, then distance), point test last.
  function automatic mul_cmd_t step_cmd(input logic [STEP_W-1:0] step);
    mul_cmd_t c;
    c = MUL_NOP;
    case (step)
      5'd0:    c = '{OPND_DX,  OPND_DX,  ACC_SET,  SH_0,   CAP_NONE};
      5'd1:    c = '{OPND_DY,  OPND_DY,  ACC_ADD,  SH_0,   CAP_NONE};
      5'd2:    c = '{OPND_EX,  OPND_DX,  ACC_SET,  SH_0,   CAP_LEN2};
      5'd3:    c = '{OPND_EY,  OPND_DY,  ACC_ADD,  SH_0,   CAP_NONE};
      5'd4:    c = '{OPND_DX,  OPND_EY,  ACC_SET,  SH_0,   CAP_DOT};
      5'd5:    c = '{OPND_DY,  OPND_EX,  ACC_SUB,  SH_0,   CAP_NONE};
      5'd6:    c = '{OPND_RW,  OPND_RW,  ACC_HOLD, SH_0,   CAP_CR};
      5'd7:    c = MUL_NOP;
      5'd8:    c = '{OPND_A0,  OPND_B0,  ACC_SET,  SH_0,   CAP_NONE};
      5'd9:    c = '{OPND_A0,  OPND_B1,  ACC_ADD,  SH_LO,  CAP_NONE};
      5'd10:   c = '{OPND_A1,  OPND_B0,  ACC_ADD,  SH_LO,  CAP_NONE};
      5'd11:   c = '{OPND_A1,  OPND_B1,  ACC_ADD,  SH_HI,  CAP_NONE};
      5'd12:   c = '{OPND_C0,  OPND_C0,  ACC_SUB,  SH_0,   CAP_NONE};
      5'd13:   c = '{OPND_C0,  OPND_C1,  ACC_SUB,  SH_LO1, CAP_NONE};
      5'd14:   c = '{OPND_C1,  OPND_C1,  ACC_SUB,  SH_HI,  CAP_NONE};
      5'd15:   c = '{OPND_DDX, OPND_DDX, ACC_SET,  SH_0,   CAP_DIST};
      5'd16:   c = '{OPND_DDY, OPND_DDY, ACC_ADD,  SH_0,   CAP_NONE};
      5'd17:   c = '{OPND_R,   OPND_R,   ACC_SUB,  SH_0,   CAP_NONE};
      default: c = MUL_NOP;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/circle_polyline_hit_test.sv =====
`timescale 1ns / 1ps
// Top level of the circle versus thick polyline hit test.
//
//  channel   handshake             payload
//  in        in_valid / in_stall   point_x point_y origin_x origin_y half_width
//                                  first_point last_point
//  out       out_valid / out_stall hit
//  cfg       cfg_valid / cfg_ready cfg_index cfg_data
//
// An item runs 18 multiplier steps, one accumulate drain and one finish between
// accepts; a first point that is not last runs only the point-test steps, and a
// single-point polyline only its finish; the one shared 26x26 multiplier sets this.
// Reset clears config, the previous point and the running hit flag to zero.
// A stalled result sits in the output register while the next item is taken; a
// last point waits in its finish cycle until that register is free.
module circle_polyline_hit_test (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [cph_pkg::COORD_W-1:0] point_x,
  input  logic signed [cph_pkg::COORD_W-1:0] point_y,
  input  logic signed [cph_pkg::COORD_W-1:0] origin_x,
  input  logic signed [cph_pkg::COORD_W-1:0] origin_y,
  input  logic [cph_pkg::HW_W-1:0]           half_width,
  input  logic                               first_point,
  input  logic                               last_point,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hit,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cph_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cph_pkg::COORD_W-1:0]        cfg_data
);
  import cph_pkg::*;

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  cph_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .first_point (first_point),
    .last_point  (last_point),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd)
  );

  cph_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point_x     (point_x),
    .point_y     (point_y),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .half_width  (half_width),
    .first_point (first_point),
    .last_point  (last_point),
    .cmd         (cmd),
    .hit         (hit)
  );

endmodule

// ===== hw/rtl/cph_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the circle hit test: config, item registers, shared multiplier, accumulator.
module cph_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [cph_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cph_pkg::COORD_W-1:0]     cfg_data,
  input  logic signed [cph_pkg::COORD_W-1:0] point_x,
  input  logic signed [cph_pkg::COORD_W-1:0] point_y,
  input  logic signed [cph_pkg::COORD_W-1:0] origin_x,
  input  logic signed [cph_pkg::COORD_W-1:0] origin_y,
  input  logic [cph_pkg::HW_W-1:0]        half_width,
  input  logic                            first_point,
  input  logic                            last_point,
  input  cph_pkg::dp_cmd_t                cmd,
  output logic                            hit
);
  import cph_pkg::*;

  typedef struct packed {
    logic               ddx_s;
    logic [MAG_W-1:0]   ddx_m;
    logic               ddy_s;
    logic [MAG_W-1:0]   ddy_m;
    logic               dx_s;
    logic [MAG_W-1:0]   dx_m;
    logic               dy_s;
    logic [MAG_W-1:0]   dy_m;
    logic               ex_s;
    logic [MAG_W-1:0]   ex_m;
    logic               ey_s;
    logic [MAG_W-1:0]   ey_m;
    logic [RW_W-1:0]    rw;
    logic [RW2_W-1:0]   rw2;
    logic [LEN2_W-1:0]  len2;
    logic [CMAG_W-1:0]  cmag;
  } opnds_t;

  function automatic logic signed [EXT_W-1:0] sx(input logic [COORD_W-1:0] v);
    return {{(EXT_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic [EXT_W-1:0] v);
    logic [EXT_W-1:0] n;
    n = v[EXT_W-1] ? (~v + 1'b1) : v;
    return n[MAG_W-1:0];
  endfunction

  function automatic logic [MAG_W:0] pick(input opnd_t s, input opnds_t o,
                                          input logic [RAD_W-1:0] r);
    logic [MAG_W:0] v;
    case (s)
      OPND_DDX: v = {o.ddx_s, o.ddx_m};
      OPND_DDY: v = {o.ddy_s, o.ddy_m};
      OPND_R:   v = {1'b0, MAG_W'(r)};
      OPND_DX:  v = {o.dx_s, o.dx_m};
      OPND_DY:  v = {o.dy_s, o.dy_m};
      OPND_EX:  v = {o.ex_s, o.ex_m};
      OPND_EY:  v = {o.ey_s, o.ey_m};
      OPND_RW:  v = {1'b0, MAG_W'(o.rw)};
      OPND_A0:  v = {1'b0, o.rw2[MAG_W-1:0]};
      OPND_A1:  v = {1'b0, MAG_W'(o.rw2[RW2_W-1:MAG_W])};
      OPND_B0:  v = {1'b0, o.len2[MAG_W-1:0]};
      OPND_B1:  v = {1'b0, MAG_W'(o.len2[LEN2_W-1:MAG_W])};
      OPND_C0:  v = {1'b0, o.cmag[MAG_W-1:0]};
      OPND_C1:  v = {1'b0, o.cmag[CMAG_W-1:MAG_W]};
      default:  v = '0;
    endcase
    return v;
  endfunction

  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic [RAD_W-1:0]          radius;
  logic [COORD_W-1:0]        prev_x;
  logic [COORD_W-1:0]        prev_y;
  logic                      hit_so_far;
  logic                      hit_so_far_next;

  opnds_t ops;
  logic   box_hit;
  logic   first_q;
  logic   last_q;

  logic signed [EXT_W-1:0] cx_e, cy_e, ox_e, oy_e, px_e, py_e, r_e, w_e;
  logic signed [EXT_W-1:0] ax, ay, ddx, ddy, dx, dy, ex, ey;
  logic                    box_miss;
  logic [RW_W-1:0]         rw_sum;

  logic [MAG_W:0]     a_op;
  logic [MAG_W:0]     b_op;
  logic [PROD_W-1:0]  prod;
  logic               prod_neg;
  mul_cmd_t           stg;

  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   acc_next;
  logic [ACC_W-1:0]   term;
  logic [ACC_W-1:0]   sterm;
  logic [CMAG_W:0]    cross_val;
  logic [CMAG_W:0]    cross_abs;
  logic [DOT_W-1:0]   dot;
  logic               dist_ok;
  logic               point_hit;
  logic               proj_ok;
  logic               item_hit;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius   <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_CENTER_Y: center_y <= cfg_data;
        CFG_RADIUS:   radius   <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Differences and box test of the incoming item.
  always_comb begin
    cx_e   = sx(center_x);
    cy_e   = sx(center_y);
    ox_e   = sx(origin_x);
    oy_e   = sx(origin_y);
    px_e   = sx(point_x);
    py_e   = sx(point_y);
    r_e    = {{(EXT_W-RAD_W){1'b0}}, radius};
    w_e    = {{(EXT_W-HW_W){1'b0}}, half_width};
    ax     = ox_e + px_e;
    ay     = oy_e + py_e;
    ddx    = cx_e - ax;
    ddy    = cy_e - ay;
    dx     = px_e - sx(prev_x);
    dy     = py_e - sx(prev_y);
    ex     = cx_e - ox_e - sx(prev_x);
    ey     = cy_e - oy_e - sx(prev_y);
    box_miss = (cx_e + r_e < ax - w_e) || (cx_e - r_e > ax + w_e) ||
               (cy_e + r_e < ay - w_e) || (cy_e - r_e > ay + w_e);
    rw_sum = RW_W'(radius) + RW_W'(half_width);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ops.ddx_s <= ddx[EXT_W-1];
      ops.ddx_m <= mag(ddx);
      ops.ddy_s <= ddy[EXT_W-1];
      ops.ddy_m <= mag(ddy);
      ops.dx_s  <= dx[EXT_W-1];
      ops.dx_m  <= mag(dx);
      ops.dy_s  <= dy[EXT_W-1];
      ops.dy_m  <= mag(dy);
      ops.ex_s  <= ex[EXT_W-1];
      ops.ex_m  <= mag(ex);
      ops.ey_s  <= ey[EXT_W-1];
      ops.ey_m  <= mag(ey);
      ops.rw    <= rw_sum;
      box_hit   <= !box_miss;
      first_q   <= first_point;
      last_q    <= last_point;
    end
    case (stg.cap)
      CAP_LEN2: ops.len2 <= acc[LEN2_W-1:0];
      CAP_DOT:  dot      <= acc[DOT_W-1:0];
      CAP_CR: begin
        ops.cmag <= cross_abs[CMAG_W-1:0];
        ops.rw2  <= prod[RW2_W-1:0];
      end
      CAP_DIST: dist_ok  <= !acc[ACC_W-1];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else if (cmd.load) begin
      prev_x <= point_x;
      prev_y <= point_y;
    end
  end

  // Multiply stage.
  assign a_op = pick(cmd.mul.a_sel, ops, radius);
  assign b_op = pick(cmd.mul.b_sel, ops, radius);

  always_ff @(posedge clk) begin
    prod     <= PROD_W'(a_op[MAG_W-1:0]) * PROD_W'(b_op[MAG_W-1:0]);
    prod_neg <= a_op[MAG_W] ^ b_op[MAG_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg <= MUL_NOP;
    end else begin
      stg <= cmd.mul;
    end
  end

  // Accumulate stage.
  always_comb begin
    case (stg.shift)
      SH_0:    term = ACC_W'(prod);
      SH_LO:   term = ACC_W'(prod) << MAG_W;
      SH_LO1:  term = ACC_W'(prod) << (MAG_W + 1);
      SH_HI:   term = ACC_W'(prod) << (2 * MAG_W);
      default: term = ACC_W'(prod);
    endcase
    sterm = (prod_neg ^ (stg.acc_op == ACC_SUB)) ? (~term + 1'b1) : term;
    case (stg.acc_op)
      ACC_HOLD: acc_next = acc;
      ACC_SET:  acc_next = sterm;
      ACC_ADD:  acc_next = acc + sterm;
      ACC_SUB:  acc_next = acc + sterm;
      default:  acc_next = acc;
    endcase
    cross_val = acc[CMAG_W:0];
    cross_abs = cross_val[CMAG_W] ? (~cross_val + 1'b1) : cross_val;
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  // Combine the tests and fold into the polyline flag.
  always_comb begin
    point_hit = acc[ACC_W-1] || (acc == '0);
    proj_ok   = (ops.len2 != '0) && !dot[DOT_W-1] &&
                (dot[DOT_W-2:0] <= (DOT_W-1)'(ops.len2));
    if (first_q && last_q) begin
      item_hit = box_hit;
    end else begin
      item_hit = point_hit || (!first_q && proj_ok && dist_ok);
    end
    hit_so_far_next = (first_q ? 1'b0 : hit_so_far) || item_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_so_far <= 1'b0;
    end else if (cmd.finish) begin
      hit_so_far <= last_q ? 1'b0 : hit_so_far_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && last_q) begin
      hit <= hit_so_far_next;
    end
  end

endmodule

// ===== hw/rtl/cph_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the circle hit test: item handshake, step sequencer and result valid.
`include "circle_polyline_hit_test_defines.svh"
module cph_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             first_point,
  input  logic             last_point,
  output logic             out_valid,
  input  logic             out_stall,
  output cph_pkg::dp_cmd_t cmd
);
  import cph_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              last_q;
  logic              out_valid_next;
  logic              accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = out_valid && out_stall;
    cmd.load       = accept;
    cmd.finish     = 1'b0;
    cmd.mul        = MUL_NOP;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (first_point && last_point) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_RUN;
            step_next  = first_point ? POINT_STEP : '0;
          end
        end
      end
      ST_RUN: begin
        cmd.mul = step_cmd(step);
        if (step == LAST_STEP) begin
          state_next = ST_DRAIN;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // A last point holds while an earlier result still waits.
        if (!last_q || !(out_valid && out_stall)) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
          if (last_q) begin
            out_valid_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      last_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
      if (accept) begin
        last_q <= last_point;
      end
    end
  end

  `CPH_ASSERT_IMPL(a_finish_out_free, clk, rst, cmd.finish && last_q, !(out_valid && out_stall))
  `CPH_ASSERT_IMPL(a_step_range, clk, rst, state == ST_RUN, step <= LAST_STEP)
  `CPH_ASSERT_NEXT(a_accept_run, clk, rst, accept && !(first_point && last_point), state == ST_RUN)
  `CPH_ASSERT_IMPL(a_result_source, clk, rst, $rose(out_valid), $past(cmd.finish && last_q))

endmodule
